// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off during reset.
`define ASSERT_IMPLIES(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error("implication check failed");

// Next-cycle implication, switched off during reset.
`define ASSERT_NEXT(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error("next-cycle check failed");

// Next-cycle implication that also holds through reset.
`define ASSERT_NEXT_ALWAYS(label, clk, lhs, rhs) \
  label: assert property (@(posedge clk) (lhs) |=> (rhs)) \
    else $error("reset-time check failed");

`endif

// ===== hw/rtl/lbs_pkg.sv =====
`timescale 1ns / 1ps
package lbs_pkg;

  // Texels of at most this many styles are summed per corner.
  localparam int MAX_STYLES = 4;
  localparam int COUNT_W = $clog2(MAX_STYLES + 1);

  localparam int NUM_CORNERS = 4;
  localparam int NUM_COLORS = 3;
  localparam int SUM_W = 20;
  localparam int PROD_W = 18;
  localparam int FRAC_W = 4;

  // Depth of the queue between front and back; a power of two.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  // One classified texel on its way to the back end.
  typedef struct packed {
    logic [1:0]                       corner;
    logic                             keep;
    logic                             last;
    logic [FRAC_W-1:0]                s_fraction;
    logic [FRAC_W-1:0]                t_fraction;
    logic [NUM_COLORS-1:0][PROD_W-1:0] prod;
  } entry_t;

  // Queue handshake as seen by one side.
  typedef struct packed {
    logic push;
    logic pop;
  } q_req_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_BLEND_S,
    ST_BLEND_T
  } back_state_t;

  // Floor blend a + floor((b - a) * f / 16); the result lies between a and b.
  function automatic logic [SUM_W-1:0] lerp_floor(input logic [SUM_W-1:0] a,
                                                  input logic [SUM_W-1:0] b,
                                                  input logic [FRAC_W-1:0] f);
    logic signed [SUM_W:0]          diff;
    logic signed [SUM_W+FRAC_W+1:0] prod;
    logic signed [SUM_W+FRAC_W+1:0] sum;
    diff = $signed({1'b0, b}) - $signed({1'b0, a});
    prod = diff * $signed({1'b0, f});
    sum = (prod >>> FRAC_W) + $signed({{(FRAC_W + 2){1'b0}}, a});
    if (sum[SUM_W+FRAC_W+1]) begin
      lerp_floor = '0;
    end else begin
      lerp_floor = sum[SUM_W-1:0];
    end
  endfunction

endpackage

// ===== hw/rtl/lbs_in_if.sv =====
`timescale 1ns / 1ps
interface lbs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [1:0] corner;
  logic [9:0] style_scale;
  logic [3:0] s_fraction;
  logic [3:0] t_fraction;
  logic       last;

  modport source (output valid, red, green, blue, corner, style_scale,
                  s_fraction, t_fraction, last, input ready);
  modport sink (input valid, red, green, blue, corner, style_scale,
                s_fraction, t_fraction, last, output ready);
endinterface

// ===== hw/rtl/lbs_out_if.sv =====
`timescale 1ns / 1ps
interface lbs_out_if;
  logic        valid;
  logic        ready;
  logic [19:0] red_level;
  logic [19:0] green_level;
  logic [19:0] blue_level;

  modport source (output valid, red_level, green_level, blue_level, input ready);
  modport sink (input valid, red_level, green_level, blue_level, output ready);
endinterface

// ===== hw/rtl/lbs_front.sv =====
`timescale 1ns / 1ps
module lbs_front (
  input  logic              clk,
  input  logic              rst,
  lbs_in_if.sink            texel,
  input  lbs_pkg::q_status_t q_status,
  output logic              push,
  output lbs_pkg::entry_t   entry
);

  logic [lbs_pkg::NUM_CORNERS-1:0][lbs_pkg::COUNT_W-1:0] count;
  logic accept;
  logic keep;

  // A beat is taken whenever the queue has room.
  assign texel.ready = !q_status.full;
  assign accept = texel.valid && !q_status.full;
  assign push = accept;

  // A corner that already holds its full set of styles drops further texels.
  assign keep = count[texel.corner] < lbs_pkg::COUNT_W'(lbs_pkg::MAX_STYLES);

  // Scale the texel colors here so the back end only adds.
  always_comb begin
    entry.corner = texel.corner;
    entry.keep = keep;
    entry.last = texel.last;
    entry.s_fraction = texel.s_fraction;
    entry.t_fraction = texel.t_fraction;
    entry.prod[0] = lbs_pkg::PROD_W'(texel.red) * lbs_pkg::PROD_W'(texel.style_scale);
    entry.prod[1] = lbs_pkg::PROD_W'(texel.green) * lbs_pkg::PROD_W'(texel.style_scale);
    entry.prod[2] = lbs_pkg::PROD_W'(texel.blue) * lbs_pkg::PROD_W'(texel.style_scale);
  end

  // Style counts restart with every sample.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      if (texel.last) begin
        count <= '0;
      end else if (keep) begin
        count[texel.corner] <= count[texel.corner] + 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/lbs_queue.sv =====
`timescale 1ns / 1ps
module lbs_queue (
  input  logic               clk,
  input  logic               rst,
  input  lbs_pkg::q_req_t    q_req,
  input  lbs_pkg::entry_t    push_data,
  output lbs_pkg::entry_t    pop_data,
  output lbs_pkg::q_status_t q_status
);

  lbs_pkg::entry_t entries [lbs_pkg::QDEPTH];
  logic [lbs_pkg::QPTR_W-1:0] wptr;
  logic [lbs_pkg::QPTR_W-1:0] rptr;
  logic [lbs_pkg::QCNT_W-1:0] cnt;

  assign q_status.full = cnt == lbs_pkg::QCNT_W'(lbs_pkg::QDEPTH);
  assign q_status.empty = cnt == '0;
  assign pop_data = entries[rptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (q_req.push) begin
      entries[wptr] <= push_data;
    end
  end

  // Pointers and fill level; pointers wrap at the power-of-two depth.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt <= '0;
    end else begin
      if (q_req.push) begin
        wptr <= wptr + 1'b1;
      end
      if (q_req.pop) begin
        rptr <= rptr + 1'b1;
      end
      if (q_req.push && !q_req.pop) begin
        cnt <= cnt + 1'b1;
      end else if (!q_req.push && q_req.pop) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/lbs_back.sv =====
`timescale 1ns / 1ps
module lbs_back (
  input  logic               clk,
  input  logic               rst,
  input  lbs_pkg::q_status_t q_status,
  input  lbs_pkg::entry_t    entry,
  output logic               pop,
  lbs_out_if.source          result
);

  lbs_pkg::back_state_t state;
  lbs_pkg::back_state_t state_next;

  logic [lbs_pkg::NUM_CORNERS-1:0][lbs_pkg::NUM_COLORS-1:0][lbs_pkg::SUM_W-1:0] sums;
  logic [lbs_pkg::NUM_COLORS-1:0][lbs_pkg::SUM_W-1:0] acc_next;
  logic [lbs_pkg::NUM_COLORS-1:0][lbs_pkg::SUM_W-1:0] top;
  logic [lbs_pkg::NUM_COLORS-1:0][lbs_pkg::SUM_W-1:0] bot;
  logic [lbs_pkg::NUM_COLORS-1:0][lbs_pkg::SUM_W-1:0] level_next;
  logic [lbs_pkg::FRAC_W-1:0] s_fraction;
  logic [lbs_pkg::FRAC_W-1:0] t_fraction;
  logic out_load;
  logic out_valid;
  logic [lbs_pkg::NUM_COLORS-1:0][lbs_pkg::SUM_W-1:0] level;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      lbs_pkg::ST_RUN: begin
        if (pop && entry.last) begin
          state_next = lbs_pkg::ST_BLEND_S;
        end
      end
      lbs_pkg::ST_BLEND_S: begin
        state_next = lbs_pkg::ST_BLEND_T;
      end
      lbs_pkg::ST_BLEND_T: begin
        if (out_load) begin
          state_next = lbs_pkg::ST_RUN;
        end
      end
      default: begin
        state_next = lbs_pkg::ST_RUN;
      end
    endcase
  end

  // State outputs.
  always_comb begin
    pop = 1'b0;
    out_load = 1'b0;
    case (state)
      lbs_pkg::ST_RUN: begin
        pop = !q_status.empty;
      end
      lbs_pkg::ST_BLEND_T: begin
        out_load = !out_valid || result.ready;
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lbs_pkg::ST_RUN;
    end else begin
      state <= state_next;
    end
  end

  // Saturating add of the scaled texel into its corner's sums.
  always_comb begin
    logic [lbs_pkg::SUM_W:0] acc;
    for (int c = 0; c < lbs_pkg::NUM_COLORS; c++) begin
      acc = {1'b0, sums[entry.corner][c]} + (lbs_pkg::SUM_W + 1)'(entry.prod[c]);
      acc_next[c] = acc[lbs_pkg::SUM_W] ? lbs_pkg::SUM_MAX : acc[lbs_pkg::SUM_W-1:0];
    end
  end

  // Corner sums; the s blend reads them and they are cleared in the same cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      sums <= '0;
    end else if (state == lbs_pkg::ST_BLEND_S) begin
      sums <= '0;
    end else if (pop && entry.keep) begin
      sums[entry.corner] <= acc_next;
    end
  end

  // The last texel carries the fractions of the sample.
  always_ff @(posedge clk) begin
    if (pop && entry.last) begin
      s_fraction <= entry.s_fraction;
      t_fraction <= entry.t_fraction;
    end
  end

  // First blend step, along s, for the t0 and t1 rows.
  always_ff @(posedge clk) begin
    if (state == lbs_pkg::ST_BLEND_S) begin
      for (int c = 0; c < lbs_pkg::NUM_COLORS; c++) begin
        top[c] <= lbs_pkg::lerp_floor(sums[0][c], sums[1][c], s_fraction);
        bot[c] <= lbs_pkg::lerp_floor(sums[2][c], sums[3][c], s_fraction);
      end
    end
  end

  // Second blend step, along t.
  always_comb begin
    for (int c = 0; c < lbs_pkg::NUM_COLORS; c++) begin
      level_next[c] = lbs_pkg::lerp_floor(top[c], bot[c], t_fraction);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      level <= level_next;
    end
  end

  assign result.valid = out_valid;
  assign result.red_level = level[0];
  assign result.green_level = level[1];
  assign result.blue_level = level[2];

endmodule

// ===== hw/rtl/lightmap_bilinear_sampler_top.sv =====
// Lightmap bilinear sampler. Each input beat carries one RGB texel of one
// of the four corners with its style scale; the block sums scaled texels per
// corner (up to four styles each, saturating at 20 bits) and, on the beat
// marked last, blends the corners along s and then t with 4-bit fractions,
// giving one result beat with 8 fractional bits per color. Texels are taken
// one per cycle while the four-entry queue between front and back has room.
// After a last texel the back end runs an s blend state, then a t blend
// state, before its result loads the output register; the result register
// lets the next sample's texels enter while a result waits.
`timescale 1ns / 1ps
module lightmap_bilinear_sampler_top (
  input  logic      clk,
  input  logic      rst,
  lbs_in_if.sink    texel,
  lbs_out_if.source result
);

  lbs_pkg::q_status_t q_status;
  lbs_pkg::q_req_t    q_req;
  lbs_pkg::entry_t    push_data;
  lbs_pkg::entry_t    pop_data;
  logic               push;
  logic               pop;

  assign q_req.push = push;
  assign q_req.pop = pop;

  lbs_front u_front (
    .clk      (clk),
    .rst      (rst),
    .texel    (texel),
    .q_status (q_status),
    .push     (push),
    .entry    (push_data)
  );

  lbs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .q_req     (q_req),
    .push_data (push_data),
    .pop_data  (pop_data),
    .q_status  (q_status)
  );

  lbs_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_status (q_status),
    .entry    (pop_data),
    .pop      (pop),
    .result   (result)
  );

endmodule

// ===== hw/rtl/lbs_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lbs_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_last,
  input logic        out_valid,
  input logic        out_ready,
  input logic [19:0] red_level,
  input logic [19:0] green_level,
  input logic [19:0] blue_level
);

  logic [3:0]  pending;
  logic        last_beat;
  logic        out_beat;
  logic        out_stall;
  logic [59:0] levels;

  assign last_beat = in_valid && in_ready && in_last;
  assign out_beat = out_valid && out_ready;
  assign out_stall = out_valid && !out_ready;
  assign levels = {red_level, green_level, blue_level};

  // Samples whose last texel went in but whose result has not come out.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (last_beat && !out_beat) begin
      pending <= pending + 1'b1;
    end else if (!last_beat && out_beat) begin
      pending <= pending - 1'b1;
    end
  end

  `ASSERT_NEXT_ALWAYS(a_reset_clears_result, clk, rst, !out_valid)
  `ASSERT_IMPLIES(a_result_has_sample, clk, rst, out_valid, pending != 4'd0)
  `ASSERT_NEXT(a_stalled_result_holds, clk, rst, out_stall, out_valid && $stable(levels))

endmodule

bind lightmap_bilinear_sampler_top lbs_checker u_lbs_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (texel.valid),
  .in_ready    (texel.ready),
  .in_last     (texel.last),
  .out_valid   (result.valid),
  .out_ready   (result.ready),
  .red_level   (result.red_level),
  .green_level (result.green_level),
  .blue_level  (result.blue_level)
);

// ===== tb/lbs_sample_checker.sv =====
`timescale 1ns / 1ps
// Watches both channels of the lightmap sampler, keeps its own copy of the
// per-corner sums, predicts the blended levels of each sample and checks
// every result beat against the oldest prediction.
module lbs_sample_checker (
  input  logic clk,
  input  logic rst,
  lbs_in_if    texel,
  lbs_out_if   result,
  output int   mismatches,
  output int   outstanding
);

  typedef struct packed {
    logic [lbs_pkg::SUM_W-1:0] red_level;
    logic [lbs_pkg::SUM_W-1:0] green_level;
    logic [lbs_pkg::SUM_W-1:0] blue_level;
  } sample_levels_t;

  logic [lbs_pkg::SUM_W-1:0] corner_sum [lbs_pkg::NUM_CORNERS][lbs_pkg::NUM_COLORS];
  int unsigned               styles_taken [lbs_pkg::NUM_CORNERS];
  sample_levels_t            level_queue [$];

  // Empties the sums and style counts, as after reset or a finished sample.
  function automatic void clear_sums();
    for (int k = 0; k < lbs_pkg::NUM_CORNERS; k++) begin
      styles_taken[k] = 0;
      for (int c = 0; c < lbs_pkg::NUM_COLORS; c++) begin
        corner_sum[k][c] = '0;
      end
    end
  endfunction

  // Adds one scaled color byte to a sum, clamping at the top of 20 bits.
  function automatic logic [lbs_pkg::SUM_W-1:0] saturate_add(
    input logic [lbs_pkg::SUM_W-1:0] sum,
    input logic [7:0]                color,
    input logic [9:0]                scale
  );
    logic [lbs_pkg::SUM_W+1:0] total;
    total = {2'b00, sum} + (lbs_pkg::SUM_W + 2)'(color) * (lbs_pkg::SUM_W + 2)'(scale);
    return (total > {2'b00, lbs_pkg::SUM_MAX}) ? lbs_pkg::SUM_MAX : total[lbs_pkg::SUM_W-1:0];
  endfunction

  // a + floor((b - a) * f / 16); the arithmetic shift on a signed value floors.
  function automatic longint floor_mix(input longint a, input longint b, input int f);
    longint prod;
    prod = (b - a) * longint'(f);
    return (prod >>> lbs_pkg::FRAC_W) + a;
  endfunction

  // Blends the four corner sums of one color, first along s, then along t.
  function automatic logic [lbs_pkg::SUM_W-1:0] blend_color(input int c, input int sf,
                                                            input int tf);
    longint upper;
    longint lower;
    longint mixed;
    upper = floor_mix(longint'(corner_sum[0][c]), longint'(corner_sum[1][c]), sf);
    lower = floor_mix(longint'(corner_sum[2][c]), longint'(corner_sum[3][c]), sf);
    mixed = floor_mix(upper, lower, tf);
    if (mixed < 0) begin
      mixed = 0;
    end
    return mixed[lbs_pkg::SUM_W-1:0];
  endfunction

  task automatic compare_field(input string name, input logic [lbs_pkg::SUM_W-1:0] want,
                               input logic [lbs_pkg::SUM_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    sample_levels_t want;
    logic [1:0]     k;
    int             sf;
    int             tf;
    if (rst) begin
      clear_sums();
      level_queue.delete();
      mismatches = 0;
    end else begin
      // A result beat is checked against the oldest predicted sample.
      if (result.valid && result.ready) begin
        if (level_queue.size() == 0) begin
          $error("result beat arrived with no sample pending");
          mismatches++;
        end else begin
          want = level_queue.pop_front();
          compare_field("red_level", want.red_level, result.red_level);
          compare_field("green_level", want.green_level, result.green_level);
          compare_field("blue_level", want.blue_level, result.blue_level);
        end
      end

      // A texel beat is folded into its corner unless the corner already
      // holds all its styles; the last beat closes the sample.
      if (texel.valid && texel.ready) begin
        k = texel.corner;
        if (styles_taken[k] < lbs_pkg::MAX_STYLES) begin
          styles_taken[k]++;
          corner_sum[k][0] = saturate_add(corner_sum[k][0], texel.red, texel.style_scale);
          corner_sum[k][1] = saturate_add(corner_sum[k][1], texel.green,
                                          texel.style_scale);
          corner_sum[k][2] = saturate_add(corner_sum[k][2], texel.blue, texel.style_scale);
        end
        if (texel.last) begin
          sf = int'(texel.s_fraction);
          tf = int'(texel.t_fraction);
          want.red_level = blend_color(0, sf, tf);
          want.green_level = blend_color(1, sf, tf);
          want.blue_level = blend_color(2, sf, tf);
          level_queue.push_back(want);
          clear_sums();
        end
      end
    end
    outstanding = level_queue.size();
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
module tb;

  localparam int     RESET_CYCLES  = 5;
  localparam int     PHASE_TEXELS  = 475;
  localparam int     HOLD_CYCLES   = 300;
  localparam int     DRAIN_CYCLES  = 20;
  localparam longint CYCLE_LIMIT   = 400000;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [1:0] corner;
    logic [9:0] style_scale;
    logic [3:0] s_fraction;
    logic [3:0] t_fraction;
    logic       last;
  } texel_beat_t;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  int     mismatch_count;
  int     pending_results;
  int     send_idle_pct = 0;
  int     stall_pct = 0;
  int     hold_requests = 0;
  int     texels_sent = 0;
  longint cycle_count = 0;

  lbs_in_if  texel_ch ();
  lbs_out_if result_ch ();

  lightmap_bilinear_sampler_top uut (
    .clk    (clk),
    .rst    (rst),
    .texel  (texel_ch),
    .result (result_ch)
  );

  lbs_sample_checker sample_check (
    .clk         (clk),
    .rst         (rst),
    .texel       (texel_ch),
    .result      (result_ch),
    .mismatches  (mismatch_count),
    .outstanding (pending_results)
  );

  always #6 clk = ~clk;

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result side: random stalls, plus long hold-offs on request so that the
  // block fills up and pushes back on its input.
  initial begin : result_taker
    int hold_left;
    int holds_served;
    hold_left = 0;
    holds_served = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_requests != holds_served) begin
        hold_left = HOLD_CYCLES;
        holds_served++;
      end
      if (rst) begin
        result_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        result_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  function automatic texel_beat_t make_texel(input logic [7:0] r, input logic [7:0] g,
                                             input logic [7:0] b, input logic [1:0] k,
                                             input logic [9:0] scale,
                                             input logic [3:0] sf, input logic [3:0] tf,
                                             input logic last);
    texel_beat_t t;
    t.red = r;
    t.green = g;
    t.blue = b;
    t.corner = k;
    t.style_scale = scale;
    t.s_fraction = sf;
    t.t_fraction = tf;
    t.last = last;
    return t;
  endfunction

  // Color bytes lean toward the extremes now and then.
  function automatic logic [7:0] pick_byte();
    int roll;
    roll = $urandom_range(9);
    if (roll == 0) begin
      return 8'd0;
    end else if (roll == 1) begin
      return 8'd255;
    end
    return 8'($urandom_range(255));
  endfunction

  function automatic texel_beat_t random_texel(input logic [1:0] k);
    int          roll;
    texel_beat_t t;
    roll = $urandom_range(19);
    t = make_texel(pick_byte(), pick_byte(), pick_byte(), k, 10'd0,
                   4'($urandom_range(15)), 4'($urandom_range(15)), 1'b0);
    if (roll == 0) begin
      t.style_scale = 10'd0;
    end else if (roll == 1) begin
      t.style_scale = 10'd256;
    end else if (roll <= 3) begin
      t.style_scale = 10'($urandom_range(1023));
    end else begin
      t.style_scale = 10'($urandom_range(550));
    end
    return t;
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat is
  // taken. Valid stays high between back-to-back beats.
  task automatic drive_texel(input texel_beat_t t);
    while ($urandom_range(99) < send_idle_pct) begin
      texel_ch.valid <= 1'b0;
      @(negedge clk);
    end
    texel_ch.valid <= 1'b1;
    texel_ch.red <= t.red;
    texel_ch.green <= t.green;
    texel_ch.blue <= t.blue;
    texel_ch.corner <= t.corner;
    texel_ch.style_scale <= t.style_scale;
    texel_ch.s_fraction <= t.s_fraction;
    texel_ch.t_fraction <= t.t_fraction;
    texel_ch.last <= t.last;
    @(posedge clk);
    while (!texel_ch.ready) @(posedge clk);
    texels_sent++;
    @(negedge clk);
  endtask

  // One sample: mostly texels on random corners, some well-formed corner sets, some with surplus styles.
  task automatic send_random_sample();
    int            mode;
    int            count;
    logic [1:0]    k;
    texel_beat_t   beats [$];
    mode = $urandom_range(9);
    if (mode <= 5) begin
      count = $urandom_range(8, 1);
      for (int i = 0; i < count; i++) begin
        beats.push_back(random_texel(2'($urandom_range(3))));
      end
    end else if (mode <= 7) begin
      for (int c = 0; c < lbs_pkg::NUM_CORNERS; c++) begin
        count = $urandom_range(lbs_pkg::MAX_STYLES, 1);
        for (int i = 0; i < count; i++) begin
          beats.push_back(random_texel(2'(c)));
        end
      end
    end else if (mode == 8) begin
      // Too many styles piled on one or two corners.
      k = 2'($urandom_range(3));
      count = $urandom_range(14, 5);
      for (int i = 0; i < count; i++) begin
        beats.push_back(random_texel($urandom_range(1) ? k : k + 2'd1));
      end
    end else begin
      beats.push_back(random_texel(2'($urandom_range(3))));
    end
    beats[beats.size() - 1].last = 1'b1;
    foreach (beats[i]) begin
      drive_texel(beats[i]);
    end
  endtask

  initial begin : stimulus
    int phase_end;
    texel_ch.valid = 1'b0;
    texel_ch.red = '0;
    texel_ch.green = '0;
    texel_ch.blue = '0;
    texel_ch.corner = '0;
    texel_ch.style_scale = '0;
    texel_ch.s_fraction = '0;
    texel_ch.t_fraction = '0;
    texel_ch.last = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: a lone texel, then all corners at full brightness.
    drive_texel(make_texel(8'd255, 8'd0, 8'd128, 2'd0, 10'd256, 4'd0, 4'd0, 1'b1));
    for (int c = 0; c < lbs_pkg::NUM_CORNERS; c++) begin
      drive_texel(make_texel(8'd255, 8'd255, 8'd255, 2'(c), 10'd550, 4'd15, 4'd15,
                             c == lbs_pkg::NUM_CORNERS - 1));
    end

    // Directed: surplus styles on one corner, ending on an ignored last beat.
    drive_texel(make_texel(8'd17, 8'd34, 8'd51, 2'd0, 10'd1023, 4'd0, 4'd0, 1'b0));
    for (int i = 0; i < lbs_pkg::MAX_STYLES + 2; i++) begin
      drive_texel(make_texel(8'd255, 8'd1, 8'd254, 2'd1, 10'd1023, 4'd0, 4'd0, 1'b0));
    end
    drive_texel(make_texel(8'd200, 8'd200, 8'd200, 2'd1, 10'd1023, 4'd15, 4'd0, 1'b1));

    // Directed: largest possible spread across t, empty corners, zero scale.
    for (int i = 0; i < lbs_pkg::MAX_STYLES; i++) begin
      drive_texel(make_texel(8'd255, 8'd255, 8'd255, 2'd3, 10'd1023, 4'd0, 4'd0, 1'b0));
    end
    drive_texel(make_texel(8'd0, 8'd0, 8'd0, 2'd0, 10'd0, 4'd8, 4'd8, 1'b1));
    drive_texel(make_texel(8'd255, 8'd128, 8'd1, 2'd2, 10'd512, 4'd0, 4'd15, 1'b1));
    drive_texel(make_texel(8'd255, 8'd255, 8'd255, 2'd1, 10'd0, 4'd15, 4'd15, 1'b1));

    // Random phases: no idling, idle sender, stalling receiver, both.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          send_idle_pct = 85;
          stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 85;
        end
        default: begin
          send_idle_pct = 13;
          stall_pct = 13;
        end
      endcase
      phase_end = texels_sent + PHASE_TEXELS;
      while (texels_sent < phase_end) begin
        send_random_sample();
      end

      // After the first phase, hold results back while texels keep coming.
      if (phase == 0) begin
        hold_requests++;
        for (int i = 0; i < 16; i++) begin
          send_random_sample();
        end
      end
    end

    texel_ch.valid <= 1'b0;
    stall_pct = 0;
    while (pending_results != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/lbs_pkg.sv
hw/rtl/lbs_in_if.sv
hw/rtl/lbs_out_if.sv
hw/rtl/lbs_front.sv
hw/rtl/lbs_queue.sv
hw/rtl/lbs_back.sv
hw/rtl/lightmap_bilinear_sampler_top.sv
hw/rtl/lbs_checker.sv
tb/lbs_sample_checker.sv
tb/tb.sv
